// ===== rtl/core/stomp_frame_parser_assert.svh =====
// assertion helpers for the stomp frame parser
`ifndef STOMP_FRAME_PARSER_ASSERT_SVH
`define STOMP_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/spf_pkg.sv =====
package spf_pkg;

    localparam int KW_COUNT = 6;

    localparam logic [5:0] KW_ALL  = 6'h3f;
    localparam logic [3:0] POS_MAX = 4'd15;

    localparam logic [2:0] KW_CONNECTED = 3'd0;
    localparam logic [2:0] KW_MESSAGE   = 3'd1;
    localparam logic [2:0] KW_RECEIPT   = 3'd2;
    localparam logic [2:0] KW_ACK       = 3'd3;
    localparam logic [2:0] KW_NACK      = 3'd4;
    localparam logic [2:0] KW_ERROR     = 3'd5;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3a;

    typedef enum logic [3:0] {
        EV_CMD_BYTE  = 4'd0,
        EV_CMD_OK    = 4'd1,
        EV_CMD_BAD   = 4'd2,
        EV_HDR_BYTE  = 4'd3,
        EV_HDR_OK    = 4'd4,
        EV_HDR_BAD   = 4'd5,
        EV_HDRS_END  = 4'd6,
        EV_BODY_BYTE = 4'd7,
        EV_FRAME_END = 4'd8,
        EV_BODY_LF   = 4'd9
    } t_event;

    typedef struct packed {
        t_event     ev;
        logic [2:0] code;
        logic [7:0] data;
        logic       in_value;
        logic       link_up;
    } t_result;

    typedef struct packed {
        logic [5:0] alive;
        logic [3:0] pos;
        logic       space_pending;
    } t_kw_state;

    typedef struct packed {
        logic [5:0] next_alive;
        logic       found;
        logic [2:0] code;
    } t_kw_match;

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] len;
        case (k)
            KW_CONNECTED: len = 4'd9;
            KW_MESSAGE:   len = 4'd7;
            KW_RECEIPT:   len = 4'd7;
            KW_ACK:       len = 4'd3;
            KW_NACK:      len = 4'd4;
            KW_ERROR:     len = 4'd5;
            default:      len = 4'd0;
        endcase
        return len;
    endfunction

    // character of keyword k at position pos, zero past its end
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
        logic [71:0] txt;
        logic [3:0]  len;
        logic [3:0]  idx;
        logic [7:0]  ch;
        len = kw_len(k);
        case (k)
            KW_CONNECTED: txt = 72'("CONNECTED");
            KW_MESSAGE:   txt = 72'("MESSAGE");
            KW_RECEIPT:   txt = 72'("RECEIPT");
            KW_ACK:       txt = 72'("ACK");
            KW_NACK:      txt = 72'("NACK");
            KW_ERROR:     txt = 72'("ERROR");
            default:      txt = '0;
        endcase
        ch = CHAR_NUL;
        if (pos < len) begin
            idx = len - pos - 4'd1;
            ch  = txt[{idx, 3'b000} +: 8];
        end
        return ch;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

// ===== rtl/core/spf_in_reg.sv =====
module spf_in_reg
    import spf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_load;

    // hold while the parsed byte cannot move on
    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_load || (r_valid && !i_take);
        end
        if (w_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/core/spf_keyword.sv =====
module spf_keyword
    import spf_pkg::*;
(
    input  t_kw_state  i_state,
    input  logic [7:0] i_byte,
    output t_kw_match  o_match
);

    logic [5:0] w_alive;

    always_comb begin
        // inner whitespace kills every keyword
        w_alive = i_state.space_pending ? 6'h00 : i_state.alive;
        o_match.next_alive = '0;
        o_match.found      = 1'b0;
        o_match.code       = KW_CONNECTED;
        for (int k = 0; k < KW_COUNT; k++) begin
            o_match.next_alive[k] = w_alive[k]
                && (i_state.pos < kw_len(3'(k)))
                && (kw_char(3'(k), i_state.pos) == i_byte);
        end
        // lowest keyword wins on a full-length match
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (i_state.alive[k] && (kw_len(3'(k)) == i_state.pos)) begin
                o_match.found = 1'b1;
                o_match.code  = 3'(k);
            end
        end
    end

endmodule

// ===== rtl/core/spf_core.sv =====
module spf_core
    import spf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_HDR  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    t_phase     r_phase,          n_phase;
    logic [5:0] r_alive,          n_alive;
    logic [3:0] r_pos,            n_pos;
    logic       r_line_started,   n_line_started;
    logic       r_space_pending,  n_space_pending;
    logic       r_colon_seen,     n_colon_seen;
    logic       r_colon_at_start, n_colon_at_start;
    logic       r_colon_is_last,  n_colon_is_last;
    logic [2:0] r_command,        n_command;
    logic       r_connected,      n_connected;

    t_kw_state w_kw_state;
    t_kw_match w_kw_match;
    logic      w_eol;
    logic      w_ws;
    logic      w_clear;

    assign w_kw_state.alive         = r_alive;
    assign w_kw_state.pos           = r_pos;
    assign w_kw_state.space_pending = r_space_pending;

    spf_keyword u_keyword (
        .i_state (w_kw_state),
        .i_byte  (i_byte),
        .o_match (w_kw_match)
    );

    assign w_eol = (i_byte == CHAR_NUL) || (i_byte == CHAR_LF);
    assign w_ws  = is_ws(i_byte);

    always_comb begin
        n_phase          = r_phase;
        n_alive          = r_alive;
        n_pos            = r_pos;
        n_line_started   = r_line_started;
        n_space_pending  = r_space_pending;
        n_colon_seen     = r_colon_seen;
        n_colon_at_start = r_colon_at_start;
        n_colon_is_last  = r_colon_is_last;
        n_command        = r_command;
        n_connected      = r_connected;
        w_clear          = 1'b0;
        o_result.ev       = EV_CMD_BYTE;
        o_result.code     = KW_CONNECTED;
        o_result.data     = 8'h00;
        o_result.in_value = 1'b0;

        case (r_phase)
            PH_BODY: begin
                if (i_byte == CHAR_NUL) begin
                    o_result.ev   = EV_FRAME_END;
                    o_result.code = r_command;
                    if (r_command == KW_CONNECTED) begin
                        n_connected = 1'b1;
                    end else if (r_command == KW_ERROR) begin
                        n_connected = 1'b0;
                    end
                    n_phase = PH_CMD;
                    w_clear = 1'b1;
                end else if (i_byte == CHAR_LF) begin
                    o_result.ev = EV_BODY_LF;
                end else begin
                    o_result.ev   = EV_BODY_BYTE;
                    o_result.data = i_byte;
                end
            end
            PH_HDR: begin
                if (w_eol) begin
                    w_clear = 1'b1;
                    if (!r_line_started) begin
                        o_result.ev = EV_HDRS_END;
                        n_phase     = PH_BODY;
                    end else if (!r_colon_seen || r_colon_at_start || r_colon_is_last) begin
                        o_result.ev = EV_HDR_BAD;
                        n_phase     = PH_CMD;
                    end else begin
                        o_result.ev = EV_HDR_OK;
                    end
                end else begin
                    o_result.ev       = EV_HDR_BYTE;
                    o_result.data     = i_byte;
                    o_result.in_value = r_colon_seen;
                    if (!w_ws) begin
                        if (r_colon_seen) begin
                            n_colon_is_last = 1'b0;
                        end else if (i_byte == CHAR_COLON) begin
                            n_colon_seen     = 1'b1;
                            n_colon_is_last  = 1'b1;
                            n_colon_at_start = !r_line_started;
                        end
                        n_line_started = 1'b1;
                    end
                end
            end
            default: begin
                if (w_eol) begin
                    w_clear = 1'b1;
                    if ((i_byte != CHAR_NUL) && w_kw_match.found) begin
                        o_result.ev   = EV_CMD_OK;
                        o_result.code = w_kw_match.code;
                        n_command     = w_kw_match.code;
                        n_phase       = PH_HDR;
                    end else begin
                        o_result.ev = EV_CMD_BAD;
                        n_phase     = PH_CMD;
                    end
                end else if (w_ws) begin
                    if (r_line_started) begin
                        n_space_pending = 1'b1;
                    end
                end else begin
                    n_alive         = w_kw_match.next_alive;
                    n_pos           = (r_pos == POS_MAX) ? r_pos : r_pos + 4'd1;
                    n_line_started  = 1'b1;
                    n_space_pending = 1'b0;
                end
            end
        endcase

        if (w_clear) begin
            n_alive          = KW_ALL;
            n_pos            = '0;
            n_line_started   = 1'b0;
            n_space_pending  = 1'b0;
            n_colon_seen     = 1'b0;
            n_colon_at_start = 1'b0;
            n_colon_is_last  = 1'b0;
        end

        o_result.link_up = n_connected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_CMD;
            r_alive          <= KW_ALL;
            r_pos            <= '0;
            r_line_started   <= 1'b0;
            r_space_pending  <= 1'b0;
            r_colon_seen     <= 1'b0;
            r_colon_at_start <= 1'b0;
            r_colon_is_last  <= 1'b0;
            r_command        <= KW_CONNECTED;
            r_connected      <= 1'b0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_alive          <= n_alive;
            r_pos            <= n_pos;
            r_line_started   <= n_line_started;
            r_space_pending  <= n_space_pending;
            r_colon_seen     <= n_colon_seen;
            r_colon_at_start <= n_colon_at_start;
            r_colon_is_last  <= n_colon_is_last;
            r_command        <= n_command;
            r_connected      <= n_connected;
        end
    end

endmodule

// ===== rtl/core/spf_out_reg.sv =====
module spf_out_reg
    import spf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // free, or emptied at this edge
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/stomp_frame_parser.sv =====
// stomp receive-frame parser: takes one stream byte per beat and returns exactly one
// result beat per byte (event code, command code, passed-on byte, after-colon flag and
// the connected flag after that byte). bytes are accepted every cycle while the result
// side does not stall: a byte lands in the input register, the per-byte parse (keyword
// compare, line trimming, colon checks, phase update) runs in combinational logic and
// the result is held in an output register, so a new byte is taken while a finished
// result waits. the sustained rate is one byte per clock; a stall on the result side
// backs up through both registers to the input stall. malformed command or header
// lines discard the frame and return to the command line; the connected flag is set
// at the end of a CONNECTED frame and cleared at the end of an ERROR frame.
module stomp_frame_parser
    import spf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte side
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    // result side
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_event_res,
    output logic [2:0] o_command_code,
    output logic [7:0] o_out_byte,
    output logic       o_in_value,
    output logic       o_link_up
);

`include "stomp_frame_parser_assert.svh"

    logic       w_byte_valid;
    logic [7:0] w_byte;
    logic       w_out_ready;
    logic       w_move;
    t_result    w_step_result;
    t_result    w_out_result;

    // a byte moves through the parse when the result register can take it
    assign w_move = w_byte_valid && w_out_ready;

    // input register
    spf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_rx_byte),
        .i_take  (w_move),
        .o_stall (o_in_stall),
        .o_valid (w_byte_valid),
        .o_byte  (w_byte)
    );

    // per-byte parse and frame state
    spf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_move),
        .i_byte   (w_byte),
        .o_result (w_step_result)
    );

    // result register
    spf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_move),
        .i_result (w_step_result),
        .i_stall  (i_out_stall),
        .o_ready  (w_out_ready),
        .o_valid  (o_out_valid),
        .o_result (w_out_result)
    );

    assign o_event_res    = w_out_result.ev;
    assign o_command_code = w_out_result.code;
    assign o_out_byte     = w_out_result.data;
    assign o_in_value     = w_out_result.in_value;
    assign o_link_up      = w_out_result.link_up;

    // passed-on byte only on header and body byte beats
    `SPF_ASSERT_NOW(a_byte_only_when_passed,
        o_out_valid && (o_event_res != EV_HDR_BYTE) && (o_event_res != EV_BODY_BYTE),
        o_out_byte == 8'h00, "out byte set on a beat that passes no byte")

    // command code only with command ok and frame end
    `SPF_ASSERT_NOW(a_code_only_when_meaningful,
        o_out_valid && (o_event_res != EV_CMD_OK) && (o_event_res != EV_FRAME_END),
        o_command_code == KW_CONNECTED, "command code set on an unrelated beat")

    // after-colon flag only on header byte beats
    `SPF_ASSERT_NOW(a_in_value_only_hdr,
        o_out_valid && (o_event_res != EV_HDR_BYTE),
        !o_in_value, "after-colon flag set outside a header byte")

    // a result taken with no byte moving leaves the output empty
    `SPF_ASSERT_NEXT(a_out_drains,
        o_out_valid && !i_out_stall && !w_move,
        !o_out_valid, "result register refilled without a parsed byte")

endmodule

// ===== verif/stomp_result_checker.sv =====
`timescale 1ns / 100ps

module stomp_result_checker
    import spf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [3:0] i_event_res,
    input  logic [2:0] i_command_code,
    input  logic [7:0] i_out_byte,
    input  logic       i_in_value,
    input  logic       i_link_up,
    output int         o_fail_count,
    output int         o_pending_count,
    output int         o_checked_count
);

    typedef enum logic [1:0] {
        PH_COMMAND,
        PH_HEADERS,
        PH_BODY
    } t_phase;

    t_phase     phase;
    logic [5:0] kw_alive;
    logic [3:0] kw_pos;
    logic       line_started;
    logic       space_pending;
    logic       colon_seen;
    logic       colon_first;
    logic       colon_last;
    logic [2:0] frame_cmd;
    logic       connected;

    t_result    expected_results[$];

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
        o_checked_count = 0;
    end

    function automatic string keyword_name(input logic [2:0] k);
        case (k)
            KW_CONNECTED: return "CONNECTED";
            KW_MESSAGE:   return "MESSAGE";
            KW_RECEIPT:   return "RECEIPT";
            KW_ACK:       return "ACK";
            KW_NACK:      return "NACK";
            KW_ERROR:     return "ERROR";
            default:      return "";
        endcase
    endfunction

    // LF counts as blank here but is caught as end of line first
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void clear_line();
        kw_alive      = KW_ALL;
        kw_pos        = '0;
        line_started  = 1'b0;
        space_pending = 1'b0;
        colon_seen    = 1'b0;
        colon_first   = 1'b0;
        colon_last    = 1'b0;
    endfunction

    function automatic void drop_frame();
        phase = PH_COMMAND;
        clear_line();
    endfunction

    function automatic t_result parse_rx_byte(input logic [7:0] c);
        t_result r;
        string   name;
        logic    eol;
        logic    found;
        r     = '0;
        eol   = (c == CHAR_NUL) || (c == CHAR_LF);
        found = 1'b0;
        case (phase)
            PH_BODY: begin
                if (c == CHAR_NUL) begin
                    r.ev   = EV_FRAME_END;
                    r.code = frame_cmd;
                    if (frame_cmd == KW_CONNECTED)
                        connected = 1'b1;
                    else if (frame_cmd == KW_ERROR)
                        connected = 1'b0;
                    drop_frame();
                end else if (c == CHAR_LF) begin
                    r.ev = EV_BODY_LF;
                end else begin
                    r.ev   = EV_BODY_BYTE;
                    r.data = c;
                end
            end
            PH_HEADERS: begin
                if (eol) begin
                    if (!line_started) begin
                        r.ev = EV_HDRS_END;
                        phase = PH_BODY;
                        clear_line();
                    end else if (!colon_seen || colon_first || colon_last) begin
                        r.ev = EV_HDR_BAD;
                        drop_frame();
                    end else begin
                        r.ev = EV_HDR_OK;
                        clear_line();
                    end
                end else begin
                    r.ev       = EV_HDR_BYTE;
                    r.data     = c;
                    r.in_value = colon_seen;
                    if (!is_blank(c)) begin
                        if (colon_seen) begin
                            colon_last = 1'b0;
                        end else if (c == CHAR_COLON) begin
                            colon_seen  = 1'b1;
                            colon_last  = 1'b1;
                            colon_first = !line_started;
                        end
                        line_started = 1'b1;
                    end
                end
            end
            default: begin
                if (eol) begin
                    if (c != CHAR_NUL) begin
                        for (int k = 0; k < KW_COUNT; k++) begin
                            name = keyword_name(3'(k));
                            if (!found && kw_alive[k] && name.len() == kw_pos) begin
                                found     = 1'b1;
                                frame_cmd = 3'(k);
                            end
                        end
                    end
                    if (found) begin
                        r.ev   = EV_CMD_OK;
                        r.code = frame_cmd;
                        phase  = PH_HEADERS;
                        clear_line();
                    end else begin
                        r.ev = EV_CMD_BAD;
                        drop_frame();
                    end
                end else begin
                    r.ev = EV_CMD_BYTE;
                    if (is_blank(c)) begin
                        if (line_started)
                            space_pending = 1'b1;
                    end else begin
                        if (space_pending)
                            kw_alive = '0;
                        for (int k = 0; k < KW_COUNT; k++) begin
                            name = keyword_name(3'(k));
                            if (kw_alive[k] && !(kw_pos < name.len() && name[kw_pos] == c))
                                kw_alive[k] = 1'b0;
                        end
                        if (kw_pos != POS_MAX)
                            kw_pos = kw_pos + 4'd1;
                        line_started  = 1'b1;
                        space_pending = 1'b0;
                    end
                end
            end
        endcase
        r.link_up = connected;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: result %0d %s: got %0h, expected %0h",
                 $time, o_checked_count, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            drop_frame();
            frame_cmd = KW_CONNECTED;
            connected = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_checked_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("beat with nothing pending", i_event_res, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_event_res !== want.ev)
                        report_mismatch("event", i_event_res, want.ev);
                    if (i_command_code !== want.code)
                        report_mismatch("command", i_command_code, want.code);
                    if (i_out_byte !== want.data)
                        report_mismatch("byte", i_out_byte, want.data);
                    if (i_in_value !== want.in_value)
                        report_mismatch("in_value", i_in_value, want.in_value);
                    if (i_link_up !== want.link_up)
                        report_mismatch("link_up", i_link_up, want.link_up);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(parse_rx_byte(i_rx_byte));
        end
        o_pending_count = expected_results.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import spf_pkg::*;

    // generous: covers the long result hold plus worst sender gaps
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 10;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] event_res;
    logic [2:0] command_code;
    logic [7:0] out_byte;
    logic       in_value;
    logic       link_up;

    int fail_count;
    int pending_count;
    int checked_count;

    // handshake mix, changed between phases
    int gap_pct = 0;
    int stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_served = 1'b0;
    int hold_left = 0;

    int bytes_sent = 0;
    int frames_sent = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    stomp_frame_parser DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_event_res    (event_res),
        .o_command_code (command_code),
        .o_out_byte     (out_byte),
        .o_in_value     (in_value),
        .o_link_up      (link_up)
    );

    stomp_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_event_res     (event_res),
        .i_command_code  (command_code),
        .i_out_byte      (out_byte),
        .i_in_value      (in_value),
        .i_link_up       (link_up),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    // result side: random stall per cycle, plus one long hold-off on request
    // so the parser's registers fill up and it stalls the byte side
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_served) begin
            out_stall   <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog: ends the run if neither channel moves a beat for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results pending",
                     quiet_cycles, pending_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic string command_word(input logic [2:0] k);
        case (k)
            KW_CONNECTED: return "CONNECTED";
            KW_MESSAGE:   return "MESSAGE";
            KW_RECEIPT:   return "RECEIPT";
            KW_ACK:       return "ACK";
            KW_NACK:      return "NACK";
            default:      return "ERROR";
        endcase
    endfunction

    // whitespace that does not end the line
    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 4))
            0:       return CHAR_TAB;
            1:       return 8'h0b;
            2:       return 8'h0c;
            3:       return CHAR_CR;
            default: return CHAR_SPACE;
        endcase
    endfunction

    // non-blank, non-colon character; now and then a high byte
    function automatic logic [7:0] rand_word_char();
        logic [7:0] ch;
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(128, 255));
        do
            ch = 8'($urandom_range(33, 126));
        while (ch == CHAR_COLON);
        return ch;
    endfunction

    // one beat on the byte side; called and returns at a falling edge.
    // valid is left high after acceptance so back-to-back beats never
    // see a low-then-high pair of assignments in one step
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // a frame with random content; most are well formed, some carry one flaw
    // on the command line or a header line and are cut off right there
    task automatic send_frame();
        string word;
        int    flaw;
        int    cut;
        word = command_word(3'($urandom_range(0, 5)));
        flaw = $urandom_range(0, 15);
        frames_sent++;
        repeat ($urandom_range(0, 2)) send_byte(rand_blank());
        case (flaw)
            0: ;  // empty command line
            1: begin
                // blank inside the keyword
                cut = $urandom_range(1, word.len() - 1);
                for (int i = 0; i < word.len(); i++) begin
                    if (i == cut)
                        send_byte(rand_blank());
                    send_byte(word[i]);
                end
            end
            2: begin
                // one character swapped out
                cut = $urandom_range(0, word.len() - 1);
                for (int i = 0; i < word.len(); i++)
                    send_byte(i == cut ? rand_word_char() : word[i]);
            end
            3: begin
                // keyword cut short
                cut = $urandom_range(1, word.len() - 1);
                for (int i = 0; i < cut; i++)
                    send_byte(word[i]);
            end
            4: begin
                // long line, past the saturation of the position count
                send_text(word);
                repeat ($urandom_range(13, 16)) send_byte(rand_word_char());
            end
            default: send_text(word);
        endcase
        repeat ($urandom_range(0, 2)) send_byte(rand_blank());
        if (flaw == 5) begin
            // NUL on the command line discards the frame
            send_byte(CHAR_NUL);
            return;
        end
        send_byte(CHAR_LF);
        if (flaw <= 4)
            return;

        // header lines: key, colon, value; flaws are no colon, colon first,
        // colon last
        repeat ($urandom_range(0, 3)) begin
            flaw = $urandom_range(0, 29);
            if ($urandom_range(0, 1))
                send_byte(rand_blank());
            if (flaw != 1)
                repeat ($urandom_range(1, 4)) send_byte(rand_word_char());
            if (flaw != 0)
                send_byte(CHAR_COLON);
            if (flaw != 2) begin
                repeat ($urandom_range(1, 5)) begin
                    case ($urandom_range(0, 7))
                        0:       send_byte(rand_blank());
                        1:       send_byte(CHAR_COLON);
                        default: send_byte(rand_word_char());
                    endcase
                end
            end
            if ($urandom_range(0, 2) == 0)
                send_byte(rand_blank());
            // NUL also ends a header line
            send_byte($urandom_range(0, 7) == 0 ? CHAR_NUL : CHAR_LF);
            if (flaw <= 2)
                return;
        end

        // blank line closes the headers
        if ($urandom_range(0, 3) == 0)
            send_byte(rand_blank());
        send_byte($urandom_range(0, 7) == 0 ? CHAR_NUL : CHAR_LF);

        // body: any nonzero byte, newlines dropped, NUL ends the frame
        repeat ($urandom_range(0, 10))
            send_byte($urandom_range(0, 5) == 0 ? CHAR_LF : 8'($urandom_range(1, 255)));
        send_byte(CHAR_NUL);
    endtask

    task automatic run_phase(input int gap, input int stall, input int byte_goal);
        gap_pct = gap;
        stall_pct <= stall;
        while (bytes_sent < byte_goal) begin
            // occasional raw noise, every byte value possible
            if ($urandom_range(0, 11) == 0)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            else
                send_frame();
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        out_stall = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: a CONNECTED frame with no headers or body brings the link up
        send_text("CONNECTED\n\n");
        send_byte(CHAR_NUL);
        // NUL on the command line
        send_byte(CHAR_NUL);
        // trimmed ACK, then a header whose colon is the first character
        send_text("\tACK \n:v\n");
        // top byte value is not blank; bad command line
        send_byte(8'hff);
        send_byte(CHAR_LF);

        // random frames under three handshake mixes
        run_phase(34, 82, 450);
        run_phase(82, 34, 880);
        hold_request <= 1'b1;
        run_phase(0, 0, 1320);

        in_valid <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("covered %0d bytes in %0d generated frames plus noise, %0d results compared",
                 bytes_sent, frames_sent, checked_count);
        $display("handshakes: gappy sender, gappy receiver, back-to-back with a long hold");
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spf_pkg.sv
rtl/core/spf_in_reg.sv
rtl/core/spf_keyword.sv
rtl/core/spf_core.sv
rtl/core/spf_out_reg.sv
rtl/core/stomp_frame_parser.sv
verif/stomp_result_checker.sv
verif/tb.sv
